FILE: hdl/gf256_arith_unit_assert.svh
// Assertion macros for the gf256_arith_unit port checker.
// Depends on nothing; included by files that assert.
`ifndef GF256_ARITH_UNIT_ASSERT_SVH
`define GF256_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define GFAU_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define GFAU_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/gfau_pkg.sv
// Package for gf256_arith_unit: codes, control word, microprogram, field helpers.
// Depends on nothing.
`default_nettype none

package gfau_pkg;

  localparam int PC_W  = 4;
  localparam int CNT_W = 4;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_MUL = 2'd1;
  localparam logic [1:0] ACT_INV = 2'd2;
  localparam logic [1:0] ACT_REM = 2'd3;

  localparam logic [7:0] MOD_RESET = 8'h1B;

  localparam logic [CNT_W-1:0] INV_LOOPS = CNT_W'(6);

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_ADD      = PC_W'(0);
  localparam pc_t PC_MUL      = PC_W'(1);
  localparam pc_t PC_INV      = PC_W'(2);
  localparam pc_t PC_INV_SQR  = PC_W'(3);
  localparam pc_t PC_INV_LOOP = PC_W'(4);
  localparam pc_t PC_INV_NEXT = PC_W'(5);
  localparam pc_t PC_INV_DONE = PC_W'(6);
  localparam pc_t PC_REM      = PC_W'(7);
  localparam pc_t PC_REM_LOOP = PC_W'(8);
  localparam pc_t PC_REM_DONE = PC_W'(9);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD,
    OP_MUL_AB,
    OP_INV_LD,
    OP_MUL_RES,
    OP_SQR,
    OP_REM_LD,
    OP_REM_STEP,
    OP_REM_FIN
  } op_t;

  typedef enum logic {JC_NONE, JC_LOOP} jc_t;
  typedef enum logic {CS_INV, CS_DIV} cnt_sel_t;

  typedef struct packed {
    op_t      op;
    logic     cnt_ld;
    cnt_sel_t cnt_sel;
    jc_t      jc;
    pc_t      target;
    logic     done;
  } cword_t;

  typedef struct packed {
    logic             take;
    logic             fire;
    op_t              op;
    logic [CNT_W-1:0] pos;
  } ctrl_t;

  function automatic pc_t dispatch(input logic [1:0] action);
    pc_t pc;
    unique case (action)
      ACT_ADD: pc = PC_ADD;
      ACT_MUL: pc = PC_MUL;
      ACT_INV: pc = PC_INV;
      ACT_REM: pc = PC_REM;
      default: pc = PC_ADD;
    endcase
    return pc;
  endfunction

  function automatic cword_t ucode(input pc_t pc);
    cword_t w;
    w.op      = OP_NOP;
    w.cnt_ld  = 1'b0;
    w.cnt_sel = CS_INV;
    w.jc      = JC_NONE;
    w.target  = PC_ADD;
    w.done    = 1'b0;
    unique case (pc)
      PC_ADD: begin
        w.op   = OP_ADD;
        w.done = 1'b1;
      end
      PC_MUL: begin
        w.op   = OP_MUL_AB;
        w.done = 1'b1;
      end
      PC_INV: begin
        w.op      = OP_INV_LD;
        w.cnt_ld  = 1'b1;
        w.cnt_sel = CS_INV;
      end
      PC_INV_SQR:  w.op = OP_SQR;
      PC_INV_LOOP: w.op = OP_MUL_RES;
      PC_INV_NEXT: begin
        w.op     = OP_SQR;
        w.jc     = JC_LOOP;
        w.target = PC_INV_LOOP;
      end
      PC_INV_DONE: w.done = 1'b1;
      PC_REM: begin
        w.op      = OP_REM_LD;
        w.cnt_ld  = 1'b1;
        w.cnt_sel = CS_DIV;
      end
      PC_REM_LOOP: begin
        w.op     = OP_REM_STEP;
        w.jc     = JC_LOOP;
        w.target = PC_REM_LOOP;
      end
      PC_REM_DONE: begin
        w.op   = OP_REM_FIN;
        w.done = 1'b1;
      end
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] red);
    logic [7:0] acc;
    logic [7:0] xs;
    acc = '0;
    xs  = x;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc = acc ^ xs;
      xs = xs[7] ? ({xs[6:0], 1'b0} ^ red) : {xs[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [2:0] top_bit(input logic [7:0] v);
    logic [2:0] d;
    d = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) d = 3'(i);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gfau_req_if.sv
// Request channel for gf256_arith_unit: valid/ready plus operation and operands.
// Depends on nothing.
`default_nettype none

interface gfau_req_if #(parameter int DIVIDEND_BITS = 13) ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [DIVIDEND_BITS-1:0] operand_a;
  logic [7:0]               operand_b;

  modport source(output valid, output action, output operand_a, output operand_b,
                 input ready);
  modport sink(input valid, input action, input operand_a, input operand_b,
               output ready);
endinterface

`default_nettype wire

FILE: hdl/gfau_rsp_if.sv
// Response channel for gf256_arith_unit: valid/ready plus result and error flag.
// Depends on nothing.
`default_nettype none

interface gfau_rsp_if ();
  logic       valid;
  logic       ready;
  logic [7:0] result_value;
  logic       divide_error;

  modport source(output valid, output result_value, output divide_error, input ready);
  modport sink(input valid, input result_value, input divide_error, output ready);
endinterface

`default_nettype wire

FILE: hdl/gfau_useq.sv
// Microcode sequencer: step counter, loop counter, control ROM and dispatch.
// Depends on gfau_pkg.
`default_nettype none

module gfau_useq #(
  parameter int DIVIDEND_BITS = 13
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic [1:0]        action,
  input  wire logic              out_free,
  output logic                   req_ready,
  output gfau_pkg::ctrl_t        ctrl
);

  localparam int CW = gfau_pkg::CNT_W;
  localparam logic [CW-1:0] DIV_LOOPS = CW'(DIVIDEND_BITS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t              state, state_next;
  gfau_pkg::pc_t       pc, pc_next;
  logic [CW-1:0]       cnt, cnt_next;
  gfau_pkg::cword_t    cw;
  logic                run;
  logic                hold;
  logic                take;

  assign cw        = gfau_pkg::ucode(pc);
  assign run       = (state == S_RUN);
  assign hold      = run && cw.done && !out_free;
  assign req_ready = (state == S_IDLE);
  assign take      = req_valid && req_ready;

  assign ctrl.take = take;
  assign ctrl.fire = run && cw.done && out_free;
  assign ctrl.op   = (run && !hold) ? cw.op : gfau_pkg::OP_NOP;
  assign ctrl.pos  = cnt;

  always_comb begin
    state_next = state;
    pc_next    = pc;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          pc_next    = gfau_pkg::dispatch(action);
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cw.done) begin
          if (out_free) state_next = S_IDLE;
        end else begin
          if (cw.cnt_ld) begin
            cnt_next = (cw.cnt_sel == gfau_pkg::CS_DIV) ? DIV_LOOPS : gfau_pkg::INV_LOOPS;
          end
          if (cw.jc == gfau_pkg::JC_LOOP && cnt != '0) begin
            cnt_next = cnt - 1'b1;
            pc_next  = cw.target;
          end else begin
            pc_next = pc + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gfau_dpath.sv
// Datapath: operand latches, shared GF(2^8) multiplier, remainder step unit.
// Depends on gfau_pkg.
`default_nettype none

module gfau_dpath #(
  parameter int DIVIDEND_BITS = 13
) (
  input  wire logic                     clk,
  input  wire gfau_pkg::ctrl_t          ctrl,
  input  wire logic [DIVIDEND_BITS-1:0] operand_a,
  input  wire logic [7:0]               operand_b,
  input  wire logic [7:0]               modulus,
  output logic [7:0]                    res_next,
  output logic                          err_next
);

  localparam int CW = gfau_pkg::CNT_W;

  logic [DIVIDEND_BITS-1:0] a_r;
  logic [7:0]               b_r;
  logic [7:0]               res;
  logic [7:0]               base, base_next;
  logic [DIVIDEND_BITS-1:0] num, num_next;
  logic [7:0]               mx, my, prod;
  logic [2:0]               db;
  logic [CW-1:0]            sh;
  logic                     hit;
  logic [DIVIDEND_BITS-1:0] dsr;

  always_comb begin
    unique case (ctrl.op)
      gfau_pkg::OP_MUL_RES: begin
        mx = res;
        my = base;
      end
      gfau_pkg::OP_SQR: begin
        mx = base;
        my = base;
      end
      default: begin
        mx = a_r[7:0];
        my = b_r;
      end
    endcase
  end

  assign prod = gfau_pkg::gf_mul(mx, my, modulus);

  assign db  = gfau_pkg::top_bit(b_r);
  assign sh  = ctrl.pos - CW'(db);
  assign hit = (b_r != '0) && (ctrl.pos >= CW'(db)) && num[ctrl.pos];
  assign dsr = DIVIDEND_BITS'(b_r) << sh;

  always_comb begin
    res_next  = res;
    base_next = base;
    num_next  = num;
    err_next  = 1'b0;
    unique case (ctrl.op)
      gfau_pkg::OP_NOP:     ;
      gfau_pkg::OP_ADD:     res_next = a_r[7:0] ^ b_r;
      gfau_pkg::OP_MUL_AB:  res_next = prod;
      gfau_pkg::OP_MUL_RES: res_next = prod;
      gfau_pkg::OP_INV_LD: begin
        res_next  = 8'd1;
        base_next = a_r[7:0];
      end
      gfau_pkg::OP_SQR:     base_next = prod;
      gfau_pkg::OP_REM_LD:  num_next = a_r;
      gfau_pkg::OP_REM_STEP: begin
        if (hit) num_next = num ^ dsr;
      end
      gfau_pkg::OP_REM_FIN: begin
        res_next = num[7:0];
        err_next = (b_r == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      a_r <= operand_a;
      b_r <= operand_b;
    end
    res  <= res_next;
    base <= base_next;
    num  <= num_next;
  end

endmodule

`default_nettype wire

FILE: hdl/gf256_arith_unit.sv
// Each operation's latency, accept edge to result valid, is set by its microprogram length
// and by back-pressure on the output register.
// One item at a time: the next item is accepted only once the previous result is registered,
// so each item passes through the single shared multiplier alone.
// Synchronous reset idles the sequencer, empties the output register and sets the
// modulus to 0x11B.
`default_nettype none

module gf256_arith_unit #(
  parameter int DIVIDEND_BITS = 13
) (
  input  wire logic       clk,
  input  wire logic       rst,
  gfau_req_if.sink        req,
  gfau_rsp_if.source      rsp,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_data
);

  gfau_pkg::ctrl_t ctrl;
  logic [7:0]      modulus;
  logic [7:0]      res_next;
  logic            err_next;
  logic            out_valid;
  logic [7:0]      out_value;
  logic            out_err;
  logic            out_free;

  assign out_free         = !out_valid || rsp.ready;
  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.divide_error = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= gfau_pkg::MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_data[7:0];
    end
  end

  gfau_useq #(.DIVIDEND_BITS(DIVIDEND_BITS)) u_useq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .action    (req.action),
    .out_free  (out_free),
    .req_ready (req.ready),
    .ctrl      (ctrl)
  );

  gfau_dpath #(.DIVIDEND_BITS(DIVIDEND_BITS)) u_dpath (
    .clk       (clk),
    .ctrl      (ctrl),
    .operand_a (req.operand_a),
    .operand_b (req.operand_b),
    .modulus   (modulus),
    .res_next  (res_next),
    .err_next  (err_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      out_value <= res_next;
      out_err   <= err_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gfau_checker.sv
// Port-level checker for gf256_arith_unit, bound to the top level.
// Depends on gf256_arith_unit_assert.svh and, through the bind, on gf256_arith_unit.
`default_nettype none
`include "gf256_arith_unit_assert.svh"

module gfau_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready
);

  logic req_acc;

  assign req_acc = req_valid && req_ready;

  `GFAU_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "item dropped")
  `GFAU_ASSERT_NEXT(a_busy_after_take, clk, rst, req_acc, !req_ready, "ready after take")
  `GFAU_ASSERT_NOW(a_idle_on_result, clk, rst, $rose(rsp_valid), req_ready, "busy at result")
  `GFAU_ASSERT_NEXT(a_no_early_result, clk, rst, req_acc, !$rose(rsp_valid), "early item")

endmodule

bind gf256_arith_unit gfau_checker u_gfau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready)
);

`default_nettype wire

FILE: sim/gfau_result_checker.sv
// Result checker for gf256_arith_unit: watches the request, response and config ports,
// predicts each result from its own GF(2^8) arithmetic and compares in order.
// Depends on gfau_pkg for the operation codes.
`default_nettype none

module gfau_result_checker #(
  parameter int DIVIDEND_BITS = 13
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  input  wire logic                     req_ready,
  input  wire logic [1:0]               req_action,
  input  wire logic [DIVIDEND_BITS-1:0] req_operand_a,
  input  wire logic [7:0]               req_operand_b,
  input  wire logic                     rsp_valid,
  input  wire logic                     rsp_ready,
  input  wire logic [7:0]               rsp_result_value,
  input  wire logic                     rsp_divide_error,
  input  wire logic                     cfg_we,
  input  wire logic [8:0]               cfg_data,
  output int unsigned                   results_owed,
  output int unsigned                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8:0] MODULUS_DEFAULT = 9'h11B;
  localparam logic [7:0] INV_EXPONENT    = 8'd254;
  localparam int         MAX_REPORTS     = 10;

  typedef struct {
    logic [1:0]               action;
    logic [DIVIDEND_BITS-1:0] operand_a;
    logic [7:0]               operand_b;
    logic [8:0]               modulus;
    logic [7:0]               result_value;
    logic                     divide_error;
  } gf_outcome_t;

  gf_outcome_t awaited_results[$];
  logic [8:0]  modulus;
  int unsigned mismatches;

  function automatic logic [7:0] field_mul(input logic [7:0] x, input logic [7:0] y,
                                           input logic [8:0] poly);
    logic [7:0] acc;
    logic [7:0] shifted;
    acc     = 8'h00;
    shifted = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) acc ^= shifted;
      if (shifted[7]) shifted = {shifted[6:0], 1'b0} ^ poly[7:0];
      else shifted = {shifted[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [7:0] field_inv(input logic [7:0] v, input logic [8:0] poly);
    logic [7:0] acc;
    logic [7:0] base;
    acc  = 8'h01;
    base = v;
    for (int k = 0; k < 8; k++) begin
      if (INV_EXPONENT[k]) acc = field_mul(acc, base, poly);
      base = field_mul(base, base, poly);
    end
    return acc;
  endfunction

  function automatic int degree_of(input logic [15:0] v);
    int d;
    d = 0;
    for (int k = 0; k < 16; k++) begin
      if (v[k]) d = k;
    end
    return d;
  endfunction

  function automatic logic [7:0] poly_rem(input logic [DIVIDEND_BITS-1:0] dividend,
                                          input logic [7:0] divisor);
    logic [15:0] rem;
    int          div_deg;
    rem     = 16'(dividend);
    div_deg = degree_of(16'(divisor));
    while (rem != 16'h0000 && degree_of(rem) >= div_deg) begin
      rem ^= 16'(divisor) << (degree_of(rem) - div_deg);
    end
    return rem[7:0];
  endfunction

  function automatic gf_outcome_t predict_outcome(input logic [1:0] action,
                                                  input logic [DIVIDEND_BITS-1:0] a,
                                                  input logic [7:0] b,
                                                  input logic [8:0] poly);
    gf_outcome_t o;
    o.action       = action;
    o.operand_a    = a;
    o.operand_b    = b;
    o.modulus      = poly;
    o.divide_error = 1'b0;
    case (action)
      gfau_pkg::ACT_ADD: o.result_value = a[7:0] ^ b;
      gfau_pkg::ACT_MUL: o.result_value = field_mul(a[7:0], b, poly);
      gfau_pkg::ACT_INV: o.result_value = field_inv(a[7:0], poly);
      default: begin
        if (b == 8'h00) begin
          o.divide_error = 1'b1;
          o.result_value = a[7:0];
        end else begin
          o.result_value = poly_rem(a, b);
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    gf_outcome_t want;
    if (rst) begin
      awaited_results.delete();
      modulus    = MODULUS_DEFAULT;
      mismatches = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result %h/%b with nothing outstanding",
                     rsp_result_value, rsp_divide_error);
        end else begin
          want = awaited_results.pop_front();
          if (rsp_result_value !== want.result_value ||
              rsp_divide_error !== want.divide_error) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: action %0d a %h b %h mod %h: expected %h/%b, got %h/%b",
                       want.action, want.operand_a, want.operand_b, want.modulus,
                       want.result_value, want.divide_error,
                       rsp_result_value, rsp_divide_error);
          end
        end
      end
      if (req_valid && req_ready)
        awaited_results = {awaited_results,
                           predict_outcome(req_action, req_operand_a,
                                           req_operand_b, modulus)};
      if (cfg_we) modulus = cfg_data;
    end
    results_owed <= awaited_results.size();
    fail_count   <= mismatches;
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Top of the gf256_arith_unit testbench: clock, reset, request and config stimulus,
// response back-pressure and the verdict. Depends on gfau_pkg, the request and
// response interfaces, gfau_result_checker and the block itself.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIV_BITS     = 13;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 192;
  localparam int TAIL_CYCLES  = 40;
  localparam int RUN_LIMIT_NS = 18_000_000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [8:0]  cfg_data;
  logic        no_stall;
  int unsigned results_owed;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned settings_used;

  gfau_req_if #(.DIVIDEND_BITS(DIV_BITS)) req_ch ();
  gfau_rsp_if rsp_ch ();

  gf256_arith_unit #(.DIVIDEND_BITS(DIV_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  gfau_result_checker #(.DIVIDEND_BITS(DIV_BITS)) u_result_checker (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_ch.valid),
    .req_ready        (req_ch.ready),
    .req_action       (req_ch.action),
    .req_operand_a    (req_ch.operand_a),
    .req_operand_b    (req_ch.operand_b),
    .rsp_valid        (rsp_ch.valid),
    .rsp_ready        (rsp_ch.ready),
    .rsp_result_value (rsp_ch.result_value),
    .rsp_divide_error (rsp_ch.divide_error),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .results_owed     (results_owed),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(input logic [1:0] act, input logic [DIV_BITS-1:0] a,
                           input logic [7:0] b);
    int unsigned gap;
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    gap = no_stall ? 0 : pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall = no_stall ? 0 : pick_gap();
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    logic [8:0]          fixed_moduli [5];
    logic [8:0]          m;
    logic [1:0]          act;
    logic [DIV_BITS-1:0] a;
    logic [7:0]          b;
    fixed_moduli = '{9'h1FF, 9'h100, 9'h01B, 9'h11D, 9'h11B};
    items_sent       = 0;
    settings_used    = 1;
    no_stall         = 1'b0;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= 9'h000;
    req_ch.valid     <= 1'b0;
    req_ch.action    <= gfau_pkg::ACT_ADD;
    req_ch.operand_a <= '0;
    req_ch.operand_b <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners at the reset modulus
    push_item(gfau_pkg::ACT_ADD, 13'h0000, 8'h00);
    push_item(gfau_pkg::ACT_ADD, 13'h1FFF, 8'hFF);
    push_item(gfau_pkg::ACT_ADD, 13'h1F00, 8'h5A);
    push_item(gfau_pkg::ACT_MUL, 13'h00FF, 8'hFF);
    push_item(gfau_pkg::ACT_MUL, 13'h0000, 8'hC3);
    push_item(gfau_pkg::ACT_MUL, 13'h0001, 8'h9E);
    push_item(gfau_pkg::ACT_MUL, 13'h0080, 8'h02);
    push_item(gfau_pkg::ACT_MUL, 13'h1E57, 8'h83);
    push_item(gfau_pkg::ACT_INV, 13'h0000, 8'hFF);
    push_item(gfau_pkg::ACT_INV, 13'h0001, 8'h00);
    push_item(gfau_pkg::ACT_INV, 13'h00FF, 8'h00);
    push_item(gfau_pkg::ACT_INV, 13'h1F53, 8'hA5);
    push_item(gfau_pkg::ACT_REM, 13'h1FFF, 8'h00);
    push_item(gfau_pkg::ACT_REM, 13'h0035, 8'h80);
    push_item(gfau_pkg::ACT_REM, 13'h000C, 8'h06);
    push_item(gfau_pkg::ACT_REM, 13'h1FFF, 8'hFF);
    push_item(gfau_pkg::ACT_REM, 13'h1FFF, 8'h01);
    push_item(gfau_pkg::ACT_REM, 13'h0000, 8'h05);
    push_item(gfau_pkg::ACT_REM, 13'h1FFF, 8'h80);
    push_item(gfau_pkg::ACT_REM, 13'h1000, 8'h1B);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      m = (p < 5) ? fixed_moduli[p] : 9'($urandom_range(256, 511));
      cfg_we   <= 1'b1;
      cfg_data <= m;
      @(posedge clk);
      cfg_we <= 1'b0;
      settings_used++;
      no_stall = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        act = 2'($urandom_range(0, 3));
        a   = DIV_BITS'($urandom);
        b   = 8'($urandom);
        case ($urandom_range(0, 15))
          0: b = 8'h00;
          1: b = 8'hFF;
          2: a = '0;
          3: a = '1;
          4: b = 8'h01 << $urandom_range(0, 7);
          5: a = DIV_BITS'($urandom_range(0, 255));
          6: b = 8'($urandom_range(1, 15));
          default: ;
        endcase
        push_item(act, a, b);
        if ($urandom_range(0, 199) == 0) drain();
      end
    end
    no_stall = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items under %0d modulus settings: all four operations,",
             items_sent, settings_used);
    $display("operand extremes, zero and high-degree divisors, %0d mismatches.", fail_count);
    if (fail_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/gfau_pkg.sv
hdl/gfau_req_if.sv
hdl/gfau_rsp_if.sv
hdl/gfau_useq.sv
hdl/gfau_dpath.sv
hdl/gf256_arith_unit.sv
hdl/gfau_checker.sv
sim/gfau_result_checker.sv
sim/tb_top.sv
